// ----- src/mieu_pkg.sv -----
// mieu_pkg: opcode codes and the control/status structs of the integer execute unit
// no dependencies; used by every module of the block
`default_nettype none

package mieu_pkg;

    localparam int unsigned OP_W   = 6;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = 5;

    localparam logic [OP_W-1:0] OP_ADD     = 6'd0;
    localparam logic [OP_W-1:0] OP_SUB     = 6'd1;
    localparam logic [OP_W-1:0] OP_AND     = 6'd2;
    localparam logic [OP_W-1:0] OP_OR      = 6'd3;
    localparam logic [OP_W-1:0] OP_XOR     = 6'd4;
    localparam logic [OP_W-1:0] OP_NOR     = 6'd5;
    localparam logic [OP_W-1:0] OP_SLT     = 6'd6;
    localparam logic [OP_W-1:0] OP_SLTU    = 6'd7;
    localparam logic [OP_W-1:0] OP_ADDI    = 6'd8;
    localparam logic [OP_W-1:0] OP_SLTI    = 6'd9;
    localparam logic [OP_W-1:0] OP_SLTI_U  = 6'd10;
    localparam logic [OP_W-1:0] OP_ANDI    = 6'd11;
    localparam logic [OP_W-1:0] OP_ORI     = 6'd12;
    localparam logic [OP_W-1:0] OP_XORI    = 6'd13;
    localparam logic [OP_W-1:0] OP_LUI     = 6'd14;
    localparam logic [OP_W-1:0] OP_SLL     = 6'd15;
    localparam logic [OP_W-1:0] OP_SRL     = 6'd16;
    localparam logic [OP_W-1:0] OP_SRA     = 6'd17;
    localparam logic [OP_W-1:0] OP_SLLV    = 6'd18;
    localparam logic [OP_W-1:0] OP_SRLV    = 6'd19;
    localparam logic [OP_W-1:0] OP_SRAV    = 6'd20;
    localparam logic [OP_W-1:0] OP_MULT    = 6'd21;
    localparam logic [OP_W-1:0] OP_MULT_U  = 6'd22;
    localparam logic [OP_W-1:0] OP_DIV     = 6'd23;
    localparam logic [OP_W-1:0] OP_DIVU    = 6'd24;
    localparam logic [OP_W-1:0] OP_MFHI    = 6'd25;
    localparam logic [OP_W-1:0] OP_MFLO    = 6'd26;
    localparam logic [OP_W-1:0] OP_MTHI    = 6'd27;
    localparam logic [OP_W-1:0] OP_MTLO    = 6'd28;
    localparam logic [OP_W-1:0] OP_BEQ     = 6'd29;
    localparam logic [OP_W-1:0] OP_BNE     = 6'd30;
    localparam logic [OP_W-1:0] OP_BGTZ    = 6'd31;
    localparam logic [OP_W-1:0] OP_BLEZ    = 6'd32;
    localparam logic [OP_W-1:0] OP_BLTZ    = 6'd33;
    localparam logic [OP_W-1:0] OP_BGEZ    = 6'd34;
    localparam logic [OP_W-1:0] OP_MTC0_SR = 6'd35;
    localparam logic [OP_W-1:0] OP_MFC0_SR = 6'd36;
    localparam logic [OP_W-1:0] OP_RFE     = 6'd37;

    // status bit that isolates the cache
    localparam int unsigned ISOLATE_BIT = 16;

    // controller to datapath
    typedef struct packed {
        logic exec;       // non-multiply/divide op: update state and load output register
        logic md_start;   // load the multiply/divide unit
        logic md_step;    // one shift-add or shift-subtract step
        logic md_finish;  // move hi/lo out of the unit, load an empty result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_muldiv;  // opcode at the input is a multiply or divide
    } sts_t;

endpackage

`default_nettype wire

// ----- src/mips1_integer_execute_unit.sv -----
// mips1_integer_execute_unit: top level of the mips-i integer execute unit
// depends on mieu_pkg, mieu_ctrl, mieu_dp (which holds mieu_muldiv)
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid, in_ready, opcode, operand_s,          | into block
//           | operand_t, immediate, shift_amount, branch_link |
//   out     | out_valid, out_ready, result, write_result,     | out of block
//           | branch_taken, link_return, cache_isolated       |
//
// alu, shift, branch, hi/lo move and status ops: the result sits in the
// output register the cycle after the transfer, and a new item is taken each cycle
// while the output side keeps up and no multiply or divide is in progress.
// mult, multu, div, divu: run on the shared 32-step shift-add /
// restoring-divide unit (a load, 32 steps, then a finish that moves the sign-fixed hi/lo out).
// reset clears hi, lo, status and all handshake state; no clearing pass.
// a stalled output holds its result and blocks the input until it is taken.
`default_nettype none

module mips1_integer_execute_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [5:0]  opcode,
    input  wire logic [31:0] operand_s,
    input  wire logic [31:0] operand_t,
    input  wire logic [15:0] immediate,
    input  wire logic [4:0]  shift_amount,
    input  wire logic        branch_link,
    // output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [31:0] result,
    output logic             write_result,
    output logic             branch_taken,
    output logic             link_return,
    output logic             cache_isolated
);
    import mieu_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // controller: handshakes, output valid, step count of the iterative unit
    mieu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: operands are read straight from the input ports, which hold
    // steady until the transfer; all lasting values live in registers here
    mieu_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (opcode),
        .operand_s      (operand_s),
        .operand_t      (operand_t),
        .immediate      (immediate),
        .shift_amount   (shift_amount),
        .branch_link    (branch_link),
        .result         (result),
        .write_result   (write_result),
        .branch_taken   (branch_taken),
        .link_return    (link_return),
        .cache_isolated (cache_isolated)
    );

endmodule

`default_nettype wire

// ----- src/mieu_muldiv.sv -----
// mieu_muldiv: iterative radix-2 multiply and restoring divide on 32-bit magnitudes
// depends on mieu_pkg for word width and opcode codes
`default_nettype none

module mieu_muldiv (
    input  wire logic                    clk,
    input  wire logic                    start,
    input  wire logic                    step,
    input  wire logic [mieu_pkg::OP_W-1:0]   opcode,
    input  wire logic [mieu_pkg::WORD_W-1:0] operand_a,
    input  wire logic [mieu_pkg::WORD_W-1:0] operand_b,
    output logic      [mieu_pkg::WORD_W-1:0] hi_out,
    output logic      [mieu_pkg::WORD_W-1:0] lo_out
);
    import mieu_pkg::*;

    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic [WORD_W-1:0]   q_reg, q_next;
    logic [WORD_W-1:0]   m_reg;
    logic                div_reg;
    logic                neg_q_reg;
    logic                neg_r_reg;

    logic                is_div;
    logic                is_sgn;
    logic                neg_a;
    logic                neg_b;
    logic [WORD_W-1:0]   mag_a;
    logic [WORD_W-1:0]   mag_b;
    logic [WORD_W:0]     rem_sh;
    logic [WORD_W+1:0]   diff;
    logic                qbit;
    logic [WORD_W:0]     sum;
    logic [2*WORD_W-1:0] prod;
    logic [2*WORD_W-1:0] prod_fix;

    // operand set-up
    always_comb
    begin
        is_div = (opcode == OP_DIV) || (opcode == OP_DIVU);
        is_sgn = (opcode == OP_MULT) || (opcode == OP_DIV);
        neg_a  = is_sgn & operand_a[WORD_W-1];
        neg_b  = is_sgn & operand_b[WORD_W-1];
        mag_a  = neg_a ? (~operand_a + 1'b1) : operand_a;
        mag_b  = neg_b ? (~operand_b + 1'b1) : operand_b;
    end

    // one step of either algorithm
    always_comb
    begin
        rem_sh = {acc_reg, q_reg[WORD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, m_reg};
        qbit   = ~diff[WORD_W+1];
        sum    = {1'b0, acc_reg} + (q_reg[0] ? {1'b0, m_reg} : '0);
        if (div_reg)
        begin
            acc_next = qbit ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            q_next   = {q_reg[WORD_W-2:0], qbit};
        end
        else
        begin
            acc_next = sum[WORD_W:1];
            q_next   = {sum[0], q_reg[WORD_W-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= '0;
            q_reg     <= mag_a;
            m_reg     <= mag_b;
            div_reg   <= is_div;
            neg_q_reg <= neg_a ^ neg_b;
            neg_r_reg <= neg_a;
        end
        else if (step)
        begin
            acc_reg <= acc_next;
            q_reg   <= q_next;
        end
    end

    // sign correction; divide by zero and the overflow case fall out of the magnitudes
    always_comb
    begin
        prod     = {acc_reg, q_reg};
        prod_fix = neg_q_reg ? (~prod + 1'b1) : prod;
        if (div_reg)
        begin
            hi_out = neg_r_reg ? (~acc_reg + 1'b1) : acc_reg;
            lo_out = neg_q_reg ? (~q_reg + 1'b1) : q_reg;
        end
        else
        begin
            hi_out = prod_fix[2*WORD_W-1:WORD_W];
            lo_out = prod_fix[WORD_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- src/mieu_dp.sv -----
// mieu_dp: alu, branch tests, hi/lo and status registers, output payload registers
// depends on mieu_pkg and mieu_muldiv
`default_nettype none

module mieu_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mieu_pkg::cmd_t              cmd,
    output mieu_pkg::sts_t                   sts,
    input  wire logic [mieu_pkg::OP_W-1:0]   opcode,
    input  wire logic [mieu_pkg::WORD_W-1:0] operand_s,
    input  wire logic [mieu_pkg::WORD_W-1:0] operand_t,
    input  wire logic [15:0]                 immediate,
    input  wire logic [4:0]                  shift_amount,
    input  wire logic                        branch_link,
    output logic      [mieu_pkg::WORD_W-1:0] result,
    output logic                             write_result,
    output logic                             branch_taken,
    output logic                             link_return,
    output logic                             cache_isolated
);
    import mieu_pkg::*;

    logic [WORD_W-1:0] hi_reg, hi_next;
    logic [WORD_W-1:0] lo_reg, lo_next;
    logic [WORD_W-1:0] status_reg, status_next;
    logic [WORD_W-1:0] result_reg;
    logic              write_reg;
    logic              taken_reg;
    logic              link_reg;
    logic              cache_reg;

    logic [WORD_W-1:0] res;
    logic              wr;
    logic              taken;
    logic              lnk;
    logic [WORD_W-1:0] imm_sx;
    logic [WORD_W-1:0] imm_zx;
    logic [WORD_W-1:0] md_hi;
    logic [WORD_W-1:0] md_lo;

    mieu_muldiv u_muldiv (
        .clk       (clk),
        .start     (cmd.md_start),
        .step      (cmd.md_step),
        .opcode    (opcode),
        .operand_a (operand_s),
        .operand_b (operand_t),
        .hi_out    (md_hi),
        .lo_out    (md_lo)
    );

    always_comb
    begin
        unique case (opcode) inside
            OP_MULT, OP_MULT_U, OP_DIV, OP_DIVU: sts.is_muldiv = 1'b1;
            default:                             sts.is_muldiv = 1'b0;
        endcase
    end

    always_comb
    begin
        imm_sx      = {{16{immediate[15]}}, immediate};
        imm_zx      = {16'h0000, immediate};
        res         = '0;
        wr          = 1'b0;
        taken       = 1'b0;
        lnk         = 1'b0;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        status_next = status_reg;
        unique case (opcode)
            OP_ADD:   begin res = operand_s + operand_t; wr = 1'b1; end
            OP_SUB:   begin res = operand_s - operand_t; wr = 1'b1; end
            OP_AND:   begin res = operand_s & operand_t; wr = 1'b1; end
            OP_OR:    begin res = operand_s | operand_t; wr = 1'b1; end
            OP_XOR:   begin res = operand_s ^ operand_t; wr = 1'b1; end
            OP_NOR:   begin res = ~(operand_s | operand_t); wr = 1'b1; end
            OP_SLT:
            begin
                res = {31'd0, $signed(operand_s) < $signed(operand_t)};
                wr  = 1'b1;
            end
            OP_SLTU:  begin res = {31'd0, operand_s < operand_t}; wr = 1'b1; end
            OP_ADDI:  begin res = operand_s + imm_sx; wr = 1'b1; end
            OP_SLTI:
            begin
                res = {31'd0, $signed(operand_s) < $signed(imm_sx)};
                wr  = 1'b1;
            end
            OP_SLTI_U: begin res = {31'd0, operand_s < imm_sx}; wr = 1'b1; end
            OP_ANDI:  begin res = operand_s & imm_zx; wr = 1'b1; end
            OP_ORI:   begin res = operand_s | imm_zx; wr = 1'b1; end
            OP_XORI:  begin res = operand_s ^ imm_zx; wr = 1'b1; end
            OP_LUI:   begin res = {immediate, 16'h0000}; wr = 1'b1; end
            OP_SLL:   begin res = operand_t << shift_amount; wr = 1'b1; end
            OP_SRL:   begin res = operand_t >> shift_amount; wr = 1'b1; end
            OP_SRA:
            begin
                res = WORD_W'($signed(operand_t) >>> shift_amount);
                wr  = 1'b1;
            end
            OP_SLLV:  begin res = operand_t << operand_s[4:0]; wr = 1'b1; end
            OP_SRLV:  begin res = operand_t >> operand_s[4:0]; wr = 1'b1; end
            OP_SRAV:
            begin
                res = WORD_W'($signed(operand_t) >>> operand_s[4:0]);
                wr  = 1'b1;
            end
            OP_MFHI:  begin res = hi_reg; wr = 1'b1; end
            OP_MFLO:  begin res = lo_reg; wr = 1'b1; end
            OP_MTHI:  hi_next = operand_s;
            OP_MTLO:  lo_next = operand_s;
            OP_BEQ:   taken = (operand_s == operand_t);
            OP_BNE:   taken = (operand_s != operand_t);
            OP_BGTZ:  taken = ~operand_s[WORD_W-1] & (operand_s != '0);
            OP_BLEZ:  taken = operand_s[WORD_W-1] | (operand_s == '0);
            OP_BLTZ:
            begin
                taken = operand_s[WORD_W-1];
                lnk   = operand_s[WORD_W-1] & branch_link;
            end
            OP_BGEZ:
            begin
                taken = ~operand_s[WORD_W-1];
                lnk   = ~operand_s[WORD_W-1] & branch_link;
            end
            OP_MTC0_SR: status_next = operand_t;
            OP_MFC0_SR: begin res = status_reg; wr = 1'b1; end
            // pop the kernel/user and interrupt-enable stack
            OP_RFE:   status_next = {status_reg[WORD_W-1:4], status_reg[5:2]};
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg     <= '0;
            lo_reg     <= '0;
            status_reg <= '0;
        end
        else if (cmd.exec)
        begin
            hi_reg     <= hi_next;
            lo_reg     <= lo_next;
            status_reg <= status_next;
        end
        else if (cmd.md_finish)
        begin
            hi_reg <= md_hi;
            lo_reg <= md_lo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            result_reg <= res;
            write_reg  <= wr;
            taken_reg  <= taken;
            link_reg   <= lnk;
            cache_reg  <= status_next[ISOLATE_BIT];
        end
        else if (cmd.md_finish)
        begin
            result_reg <= '0;
            write_reg  <= 1'b0;
            taken_reg  <= 1'b0;
            link_reg   <= 1'b0;
            cache_reg  <= status_reg[ISOLATE_BIT];
        end
    end

    assign result         = result_reg;
    assign write_result   = write_reg;
    assign branch_taken   = taken_reg;
    assign link_return    = link_reg;
    assign cache_isolated = cache_reg;

endmodule

`default_nettype wire

// ----- src/mieu_ctrl.sv -----
// mieu_ctrl: handshake control, output valid and the multiply/divide step sequencer
// depends on mieu_pkg for the command and status structs
`default_nettype none

module mieu_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire mieu_pkg::sts_t sts,
    output mieu_pkg::cmd_t      cmd
);
    import mieu_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        in_ready       = 1'b0;
        accept         = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = ~out_valid_reg | out_ready;
                accept   = in_valid & in_ready;
                if (accept)
                begin
                    if (sts.is_muldiv)
                    begin
                        cmd.md_start = 1'b1;
                        count_next   = '0;
                        state_next   = ST_RUN;
                    end
                    else
                    begin
                        cmd.exec       = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.md_step = 1'b1;
                count_next  = count_reg + 1'b1;
                if (count_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // output register is empty here: it was free when the item came in
                cmd.md_finish  = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
